// File: rtl/core/cfbs_pkg.sv
package cfbs_pkg;

	localparam int STORE_W    = 27;
	localparam int TOTAL_W    = 35;
	localparam int SQ_W       = 62;
	localparam int PROD_W     = 72;
	localparam int DVD_W      = 88;
	localparam int RAD_W      = 70;
	localparam int OUT_W      = 35;
	localparam int POS_W      = 11;
	localparam int FC_W       = 9;
	localparam int WL_W       = 11;
	localparam int DLT_W      = 17;
	localparam int CNT_W      = 7;
	localparam int SREM_W     = 37;
	localparam int MUL_STEPS  = 35;
	localparam int DIV_STEPS  = 88;
	localparam int SQRT_STEPS = 35;
	localparam int DEV_SHIFT  = 16;
	localparam int FRAC_BITS  = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

	typedef struct packed {
		logic [7:0]  flow;
		logic        outgoing;
		logic [15:0] payload_size;
		logic        last_flow;
	} cfbs_in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [OUT_W-1:0] mean_incoming;
		logic [OUT_W-1:0] deviation_incoming;
		logic [OUT_W-1:0] mean_outgoing;
		logic [OUT_W-1:0] deviation_outgoing;
		logic             final_position;
	} cfbs_out_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_READ,
		OP_UPDATE,
		OP_SQUARE,
		OP_MUL_NS,
		OP_MUL_TT,
		OP_CHECK,
		OP_DIV_DEV,
		OP_SQRT,
		OP_DIV_MEAN,
		OP_EMIT,
		OP_CLEAR
	} cfbs_op_t;

	typedef struct packed {
		cfbs_op_t op;
		logic     start;
		logic     dir;
	} cfbs_cmd_t;

	typedef struct packed {
		logic done;
		logic last;
		logic dev_zero;
		logic out_free;
		logic run_end;
	} cfbs_status_t;

endpackage

// File: rtl/core/cfbs_ctrl.sv
module cfbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pkt_valid,
	input  cfbs_pkg::cfbs_status_t status,
	output cfbs_pkg::cfbs_cmd_t   cmd,
	output logic                  pkt_stall
);
	import cfbs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_UPD, S_SQ, S_MUL_NS, S_MUL_TT, S_CHK,
		S_DIV_DEV, S_SQRT, S_DIV_MEAN, S_EMIT, S_CLR
	} state_t;

	state_t state_q;
	logic   dir_q;
	logic   start_q;

	// sequencer: item update; after a last_flow item, per-direction statistics, then emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			dir_q   <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pkt_valid) state_q <= S_READ;
				end
				S_READ: state_q <= S_UPD;
				S_UPD:  state_q <= S_SQ;
				S_SQ: begin
					if (status.last) begin
						state_q <= S_MUL_NS;
						dir_q   <= 1'b0;
						start_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL_NS: begin
					if (status.done) begin
						state_q <= S_MUL_TT;
						start_q <= 1'b1;
					end
				end
				S_MUL_TT: begin
					if (status.done) state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= status.dev_zero ? S_DIV_MEAN : S_DIV_DEV;
					start_q <= 1'b1;
				end
				S_DIV_DEV: begin
					if (status.done) begin
						state_q <= S_SQRT;
						start_q <= 1'b1;
					end
				end
				S_SQRT: begin
					if (status.done) begin
						state_q <= S_DIV_MEAN;
						start_q <= 1'b1;
					end
				end
				S_DIV_MEAN: begin
					if (status.done) begin
						if (!dir_q) begin
							dir_q   <= 1'b1;
							state_q <= S_MUL_NS;
							start_q <= 1'b1;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (status.out_free) state_q <= status.run_end ? S_CLR : S_IDLE;
				end
				// store clearing pass after reset and at the end of a run
				S_CLR: begin
					if (status.done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.start = start_q;
		cmd.dir   = dir_q;
		unique case (state_q)
			S_IDLE:     cmd.op = OP_IDLE;
			S_READ:     cmd.op = OP_READ;
			S_UPD:      cmd.op = OP_UPDATE;
			S_SQ:       cmd.op = OP_SQUARE;
			S_MUL_NS:   cmd.op = OP_MUL_NS;
			S_MUL_TT:   cmd.op = OP_MUL_TT;
			S_CHK:      cmd.op = OP_CHECK;
			S_DIV_DEV:  cmd.op = OP_DIV_DEV;
			S_SQRT:     cmd.op = OP_SQRT;
			S_DIV_MEAN: cmd.op = OP_DIV_MEAN;
			S_EMIT:     cmd.op = OP_EMIT;
			S_CLR:      cmd.op = OP_CLEAR;
			default:    cmd.op = OP_IDLE;
		endcase
	end

	assign pkt_stall = (state_q != S_IDLE);

endmodule

// File: rtl/core/cfbs_datapath.sv
module cfbs_datapath #(
	parameter int MAX_FLOWS  = 256,
	parameter int MAX_WINDOW = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pkt_valid,
	input  cfbs_pkg::cfbs_in_t                  pkt,
	input  logic                                stat_stall,
	output logic                                stat_valid,
	output cfbs_pkg::cfbs_out_t                 stat,
	input  logic                                cfg_valid,
	input  logic [cfbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cfbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  cfbs_pkg::cfbs_cmd_t                 cmd,
	output cfbs_pkg::cfbs_status_t              status
);
	import cfbs_pkg::*;

	localparam int DEPTH  = (MAX_FLOWS < 256) ? MAX_FLOWS : 256;
	localparam int AW     = $clog2(DEPTH);
	localparam int ENTRIES = 2 << AW;
	localparam int NW     = $clog2(MAX_FLOWS + 1);
	localparam int DW     = 2 * NW;
	localparam int PW     = $clog2(MAX_WINDOW);
	localparam int SQP_W  = DLT_W + STORE_W + 1;

	// configuration
	logic [FC_W-1:0] fc_q;
	logic [WL_W-1:0] wl_q;

	// item and store
	cfbs_in_t             item_q;
	logic [STORE_W-1:0]   store_mem [0:ENTRIES-1];
	logic [STORE_W-1:0]   rd_q;
	logic [AW:0]          addr;
	logic [AW:0]          clr_q;

	// accumulators
	logic [TOTAL_W-1:0]   total_q [0:1];
	logic [SQ_W-1:0]      squares_q [0:1];
	logic [PW-1:0]        pos_q;
	logic [DLT_W-1:0]     d_q;
	logic [STORE_W:0]     s_q;

	// serial units
	logic [CNT_W-1:0]     cnt_q;
	logic [PROD_W-1:0]    mul_a_q, mul_p_q, ns_q, tt_q, diff_q;
	logic [TOTAL_W-1:0]   mul_b_q;
	logic [DVD_W-1:0]     dvd_q, q_q;
	logic [DW-1:0]        dvs_q, m_q, rem_q;
	logic [RAD_W-1:0]     rad_q;
	logic                 sat_q;
	logic [SREM_W-1:0]    srem_q;
	logic [OUT_W-1:0]     root_q;
	logic [OUT_W-1:0]     mean_q [0:1];
	logic [OUT_W-1:0]     dev_q [0:1];

	logic                 out_valid_q;
	cfbs_out_t            out_q;

	logic [NW-1:0]        n_eff;
	logic [PW-1:0]        len_m1;
	logic                 hit, last_pos, out_free, unit_op, done;
	logic [STORE_W-1:0]   old_v, nv;
	logic [STORE_W:0]     sum_v;
	logic [STORE_W-1:0]   delta;
	logic [SQP_W-1:0]     sq_prod;
	logic [DW-1:0]        pair_prod;
	logic [PROD_W-1:0]    p_next;
	logic [DW:0]          rem_sh;
	logic                 div_ge;
	logic [DW-1:0]        rem_nx;
	logic [DVD_W-1:0]     dvd_nx;
	logic [SREM_W+1:0]    srem_sh, trial;
	logic                 sq_ge;
	logic [SREM_W-1:0]    srem_nx;
	logic [OUT_W-1:0]     root_nx;

	// clamped configuration
	always_comb begin
		if (fc_q == '0) n_eff = NW'(1);
		else if (int'(fc_q) > MAX_FLOWS) n_eff = NW'(MAX_FLOWS);
		else n_eff = NW'(fc_q);
		if (wl_q == '0) len_m1 = '0;
		else if (int'(wl_q) > MAX_WINDOW - 1) len_m1 = PW'(MAX_WINDOW - 2);
		else len_m1 = PW'(wl_q - 1'b1);
	end

	assign hit      = (int'(item_q.flow) < int'(n_eff));
	assign addr     = {item_q.outgoing, item_q.flow[AW-1:0]};
	assign last_pos = (pos_q == len_m1);
	assign out_free = !out_valid_q || !stat_stall;

	// saturating store update
	always_comb begin
		old_v = rd_q;
		sum_v = {1'b0, old_v} + (STORE_W+1)'(item_q.payload_size);
		nv    = sum_v[STORE_W] ? '1 : sum_v[STORE_W-1:0];
		delta = nv - old_v;
	end

	// square increment as (new - old) * (new + old); n * (n - 1) for the deviation
	assign sq_prod   = SQP_W'(d_q) * SQP_W'(s_q);
	assign pair_prod = DW'(n_eff) * DW'(n_eff - 1'b1);

	// one step of each serial unit
	always_comb begin
		p_next  = mul_b_q[0] ? mul_p_q + mul_a_q : mul_p_q;
		rem_sh  = {rem_q, dvd_q[DVD_W-1]};
		div_ge  = (rem_sh >= {1'b0, dvs_q});
		rem_nx  = div_ge ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
		dvd_nx  = {dvd_q[DVD_W-2:0], div_ge};
		srem_sh = {srem_q, rad_q[RAD_W-1:RAD_W-2]};
		trial   = (SREM_W+2)'({root_q, 2'b01});
		sq_ge   = (srem_sh >= trial);
		srem_nx = sq_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
		root_nx = {root_q[OUT_W-2:0], sq_ge};
	end

	always_comb begin
		unit_op = (cmd.op == OP_MUL_NS) || (cmd.op == OP_MUL_TT) ||
			(cmd.op == OP_DIV_DEV) || (cmd.op == OP_SQRT) ||
			(cmd.op == OP_DIV_MEAN);
		done = (unit_op && !cmd.start && (cnt_q == '0)) ||
			((cmd.op == OP_CLEAR) && (&clr_q));
	end

	always_comb begin
		status.done     = done;
		status.last     = item_q.last_flow;
		status.dev_zero = (n_eff < NW'(2)) || (ns_q < tt_q);
		status.out_free = out_free;
		status.run_end  = last_pos;
	end

	// control state: config, clear address, sums, position, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q         <= FC_W'(1);
			wl_q         <= WL_W'(1);
			clr_q        <= '0;
			total_q[0]   <= '0;
			total_q[1]   <= '0;
			squares_q[0] <= '0;
			squares_q[1] <= '0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FLOW_COUNT:    fc_q <= cfg_data[FC_W-1:0];
					CFG_WINDOW_LENGTH: wl_q <= cfg_data[WL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd.op == OP_UPDATE && hit) begin
				total_q[item_q.outgoing] <= total_q[item_q.outgoing] +
					TOTAL_W'(delta);
			end
			if (cmd.op == OP_SQUARE) begin
				squares_q[item_q.outgoing] <= squares_q[item_q.outgoing] +
					SQ_W'(sq_prod);
			end
			if (cmd.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				if (last_pos) begin
					total_q[0]   <= '0;
					total_q[1]   <= '0;
					squares_q[0] <= '0;
					squares_q[1] <= '0;
					pos_q        <= '0;
				end else if (int'(pos_q) + 1 >= MAX_WINDOW) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (!stat_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// store memory: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.op == OP_READ) rd_q <= store_mem[addr];
		if (cmd.op == OP_UPDATE && hit) store_mem[addr] <= nv;
		else if (cmd.op == OP_CLEAR) store_mem[clr_q] <= '0;
	end

	// payload registers and serial units
	always_ff @(posedge clk) begin
		if (cmd.op == OP_IDLE && pkt_valid) item_q <= pkt;
		if (cmd.op == OP_UPDATE) begin
			d_q <= hit ? delta[DLT_W-1:0] : '0;
			s_q <= {1'b0, nv} + {1'b0, old_v};
		end

		if (unit_op && !cmd.start) cnt_q <= cnt_q - 1'b1;

		case (cmd.op)
			OP_MUL_NS, OP_MUL_TT: begin
				if (cmd.start) begin
					cnt_q   <= CNT_W'(MUL_STEPS - 1);
					mul_p_q <= '0;
					if (cmd.op == OP_MUL_NS) begin
						mul_a_q <= PROD_W'(squares_q[cmd.dir]);
						mul_b_q <= TOTAL_W'(n_eff);
					end else begin
						mul_a_q <= PROD_W'(total_q[cmd.dir]);
						mul_b_q <= total_q[cmd.dir];
					end
				end else begin
					mul_p_q <= p_next;
					mul_a_q <= {mul_a_q[PROD_W-2:0], 1'b0};
					mul_b_q <= {1'b0, mul_b_q[TOTAL_W-1:1]};
					if (done) begin
						if (cmd.op == OP_MUL_NS) ns_q <= p_next;
						else tt_q <= p_next;
					end
				end
			end
			OP_CHECK: begin
				diff_q <= ns_q - tt_q;
				m_q    <= pair_prod;
				if (status.dev_zero) dev_q[cmd.dir] <= '0;
			end
			OP_DIV_DEV, OP_DIV_MEAN: begin
				if (cmd.start) begin
					cnt_q <= CNT_W'(DIV_STEPS - 1);
					rem_q <= '0;
					if (cmd.op == OP_DIV_DEV) begin
						dvd_q <= {diff_q, DEV_SHIFT'(0)};
						dvs_q <= m_q;
					end else begin
						dvd_q <= DVD_W'({total_q[cmd.dir], FRAC_BITS'(0)});
						dvs_q <= DW'(n_eff);
					end
				end else begin
					rem_q <= rem_nx;
					dvd_q <= dvd_nx;
					if (done) begin
						if (cmd.op == OP_DIV_DEV) q_q <= dvd_nx;
						else mean_q[cmd.dir] <= dvd_nx[OUT_W-1:0];
					end
				end
			end
			OP_SQRT: begin
				if (cmd.start) begin
					cnt_q  <= CNT_W'(SQRT_STEPS - 1);
					rad_q  <= q_q[RAD_W-1:0];
					sat_q  <= |q_q[DVD_W-1:RAD_W];
					srem_q <= '0;
					root_q <= '0;
				end else begin
					srem_q <= srem_nx;
					root_q <= root_nx;
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					if (done) dev_q[cmd.dir] <= sat_q ? '1 : root_nx;
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					out_q.position           <= POS_W'(pos_q);
					out_q.mean_incoming      <= mean_q[0];
					out_q.deviation_incoming <= dev_q[0];
					out_q.mean_outgoing      <= mean_q[1];
					out_q.deviation_outgoing <= dev_q[1];
					out_q.final_position     <= last_pos;
				end
			end
			default: ;
		endcase
	end

	assign stat_valid = out_valid_q;
	assign stat       = out_q;

endmodule

// File: rtl/core/cumulative_flow_byte_stats.sv
// Packet item: store read, saturating update and square add before the next item is accepted.
// Item with last_flow: per direction, the shared bit-serial multiplier, restoring divider and
// square-root unit give mean and deviation; a zero deviation skips its division and root.
// Result waits in an output register; the next item is taken while it waits.
// Reset (arst_n low): flow_count = 1, window_length = 1, sums and position cleared;
// after reset and after each run's final result a clearing pass zeroes every store entry.
module cumulative_flow_byte_stats #(
	parameter int MAX_FLOWS  = 256,
	parameter int MAX_WINDOW = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pkt_valid,
	output logic                            pkt_stall,
	input  cfbs_pkg::cfbs_in_t              pkt,
	output logic                            stat_valid,
	input  logic                            stat_stall,
	output cfbs_pkg::cfbs_out_t             stat,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cfbs_pkg::*;

	cfbs_cmd_t    cmd;
	cfbs_status_t status;

	assign cfg_ready = 1'b1;

	cfbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.status    (status),
		.cmd       (cmd),
		.pkt_stall (pkt_stall)
	);

	cfbs_datapath #(
		.MAX_FLOWS  (MAX_FLOWS),
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_valid  (pkt_valid),
		.pkt        (pkt),
		.stat_stall (stat_stall),
		.stat_valid (stat_valid),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
